// File: sv/mleq_pkg.sv
// Package for the line envelope query block.
// Holds field widths, operation and result codes, and the controller/datapath
// command and status types. Depends on nothing.
package mleq_pkg;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned MulW    = 33;
  localparam int unsigned ProdW   = 66;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned SizeW   = 7;
  localparam int unsigned OpW     = 3;
  localparam int unsigned KindW   = 2;
  localparam int unsigned WordW   = 2 * CoefW;
  localparam int unsigned InDataW = 96;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 3'd0,
    OP_BUILD = 3'd1,
    OP_QUERY = 3'd2,
    OP_SHIFT = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_QUERY = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_FULL  = 2'd2,
    KIND_SAT   = 2'd3
  } kind_e;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_ADD,
    DP_CLEAR,
    DP_SET_I1,
    DP_H_INIT,
    DP_RD_I,
    DP_CUR_LD,
    DP_SORT_INS,
    DP_RD_JM1,
    DP_SORT_CMP,
    DP_RD_TOP1,
    DP_EQ_CHK,
    DP_L1_RD_TOP2,
    DP_L0_LD,
    DP_MUL1,
    DP_MUL2,
    DP_CV_CMP,
    DP_PUSH,
    DP_BUILD_END,
    DP_Q_INIT,
    DP_Q_MID,
    DP_Q_RD2,
    DP_Q_L0,
    DP_Q_MUL,
    DP_Q_STEP,
    DP_Q_RDLO,
    DP_Q_F1,
    DP_Q_F2,
    DP_Q_F3,
    DP_SH_I0,
    DP_SH_WR
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE,
    ST_SORT_I, ST_SORT_LD, ST_SORT_J, ST_SORT_CMP,
    ST_H_I, ST_H_LD, ST_H_EQ, ST_H_EQC, ST_H_CV, ST_H_CV1, ST_H_CV2,
    ST_H_M1, ST_H_M2, ST_H_CMP, ST_H_PUSH,
    ST_Q_LOOP, ST_Q_R1, ST_Q_R2, ST_Q_MUL, ST_Q_STEP, ST_Q_F1, ST_Q_F2, ST_Q_F3,
    ST_S_I, ST_S_W, ST_EMIT
  } state_e;

  typedef struct packed {
    dp_op_e op;
    logic   push;
    kind_e  kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic full;
    logic hull_empty;
    logic i_lt_cnt;
    logic j_zero;
    logic top_gt0;
    logic top_gt1;
    logic sort_gt;
    logic eq_dom;
    logic cv_le;
    logic lo_lt_hi;
    logic sat;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/mleq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the line store. Depends on nothing.
module mleq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/mleq_ctrl.sv
// Controller state machine of the line envelope query block.
// Sequences add, build, query, shift and clear as datapath micro-operations.
// Depends on mleq_pkg.
module mleq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mleq_pkg::dp_status_t stat_i,
  output mleq_pkg::dp_cmd_t    cmd_o
);
  import mleq_pkg::*;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  // State and pending result kind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_QUERY;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.push = 1'b0;
    cmd_o.kind = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.op)
          OP_ADD: begin
            if (stat_i.full) begin
              kind_d  = KIND_FULL;
              state_d = ST_EMIT;
            end else begin
              cmd_o.op = DP_ADD;
              state_d  = ST_IDLE;
            end
          end
          OP_BUILD: begin
            cmd_o.op = DP_SET_I1;
            state_d  = ST_SORT_I;
          end
          OP_QUERY: begin
            cmd_o.op = DP_Q_INIT;
            if (stat_i.hull_empty) begin
              kind_d  = KIND_QUERY;
              state_d = ST_EMIT;
            end else begin
              state_d = ST_Q_LOOP;
            end
          end
          OP_SHIFT: begin
            cmd_o.op = DP_SH_I0;
            state_d  = ST_S_I;
          end
          OP_CLEAR: begin
            cmd_o.op = DP_CLEAR;
            state_d  = ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      // Insertion sort by slope, then intercept.
      ST_SORT_I: begin
        if (stat_i.i_lt_cnt) begin
          cmd_o.op = DP_RD_I;
          state_d  = ST_SORT_LD;
        end else begin
          cmd_o.op = DP_H_INIT;
          state_d  = ST_H_I;
        end
      end
      ST_SORT_LD: begin
        cmd_o.op = DP_CUR_LD;
        state_d  = ST_SORT_J;
      end
      ST_SORT_J: begin
        if (stat_i.j_zero) begin
          cmd_o.op = DP_SORT_INS;
          state_d  = ST_SORT_I;
        end else begin
          cmd_o.op = DP_RD_JM1;
          state_d  = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        cmd_o.op = DP_SORT_CMP;
        state_d  = stat_i.sort_gt ? ST_SORT_J : ST_SORT_I;
      end
      // Hull compaction with a stack kept in the low entries.
      ST_H_I: begin
        if (stat_i.i_lt_cnt) begin
          cmd_o.op = DP_RD_I;
          state_d  = ST_H_LD;
        end else begin
          cmd_o.op = DP_BUILD_END;
          kind_d   = KIND_BUILD;
          state_d  = ST_EMIT;
        end
      end
      ST_H_LD: begin
        cmd_o.op = DP_CUR_LD;
        state_d  = ST_H_EQ;
      end
      ST_H_EQ: begin
        if (stat_i.top_gt0) begin
          cmd_o.op = DP_RD_TOP1;
          state_d  = ST_H_EQC;
        end else begin
          state_d = ST_H_PUSH;
        end
      end
      ST_H_EQC: begin
        cmd_o.op = DP_EQ_CHK;
        state_d  = stat_i.eq_dom ? ST_H_EQ : ST_H_CV;
      end
      ST_H_CV: begin
        if (stat_i.top_gt1) begin
          cmd_o.op = DP_RD_TOP1;
          state_d  = ST_H_CV1;
        end else begin
          state_d = ST_H_PUSH;
        end
      end
      ST_H_CV1: begin
        cmd_o.op = DP_L1_RD_TOP2;
        state_d  = ST_H_CV2;
      end
      ST_H_CV2: begin
        cmd_o.op = DP_L0_LD;
        state_d  = ST_H_M1;
      end
      ST_H_M1: begin
        cmd_o.op = DP_MUL1;
        state_d  = ST_H_M2;
      end
      ST_H_M2: begin
        cmd_o.op = DP_MUL2;
        state_d  = ST_H_CMP;
      end
      ST_H_CMP: begin
        cmd_o.op = DP_CV_CMP;
        state_d  = stat_i.cv_le ? ST_H_CV : ST_H_PUSH;
      end
      ST_H_PUSH: begin
        cmd_o.op = DP_PUSH;
        state_d  = ST_H_I;
      end
      // Binary search over the hull.
      ST_Q_LOOP: begin
        if (stat_i.lo_lt_hi) begin
          cmd_o.op = DP_Q_MID;
          state_d  = ST_Q_R1;
        end else begin
          cmd_o.op = DP_Q_RDLO;
          state_d  = ST_Q_F1;
        end
      end
      ST_Q_R1: begin
        cmd_o.op = DP_Q_RD2;
        state_d  = ST_Q_R2;
      end
      ST_Q_R2: begin
        cmd_o.op = DP_Q_L0;
        state_d  = ST_Q_MUL;
      end
      ST_Q_MUL: begin
        cmd_o.op = DP_Q_MUL;
        state_d  = ST_Q_STEP;
      end
      ST_Q_STEP: begin
        cmd_o.op = DP_Q_STEP;
        state_d  = ST_Q_LOOP;
      end
      ST_Q_F1: begin
        cmd_o.op = DP_Q_F1;
        state_d  = ST_Q_F2;
      end
      ST_Q_F2: begin
        cmd_o.op = DP_Q_F2;
        state_d  = ST_Q_F3;
      end
      ST_Q_F3: begin
        cmd_o.op = DP_Q_F3;
        kind_d   = KIND_QUERY;
        state_d  = ST_EMIT;
      end
      // Shift every stored line.
      ST_S_I: begin
        if (stat_i.i_lt_cnt) begin
          cmd_o.op = DP_RD_I;
          state_d  = ST_S_W;
        end else if (stat_i.sat) begin
          kind_d  = KIND_SAT;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_S_W: begin
        cmd_o.op = DP_SH_WR;
        state_d  = ST_S_I;
      end
      // Hand the result to the output register once it is free.
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: sv/mleq_dp.sv
// Datapath of the line envelope query block: line store RAM, indices,
// working lines, the shared 33x33 multiplier and the output register.
// Depends on mleq_pkg and mleq_ram.
module mleq_dp #(
  parameter int unsigned MAX_LINES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mleq_pkg::dp_cmd_t            cmd_i,
  output mleq_pkg::dp_status_t         stat_o,
  input  logic [mleq_pkg::OpW-1:0]     in_op_i,
  input  logic [mleq_pkg::InDataW-1:0] in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mleq_pkg::KindW-1:0]   out_kind_o,
  output logic [mleq_pkg::OutDataW-1:0] out_data_o
);
  import mleq_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LINES);
  localparam int unsigned CW = $clog2(MAX_LINES + 1);

  // Captured request.
  logic [OpW-1:0]          op_q;
  logic signed [CoefW-1:0] s_q, c_q, x_q;

  // Counts and indices.
  logic [CW-1:0] cnt_q, hcnt_q, i_q, j_q, top_q, lo_q, hi_q, mid_q;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_c;

  // Working lines: cur is the line being placed, l1/l0 are read neighbors.
  logic signed [CoefW-1:0] ca_q, cb_q, l1a_q, l1b_q, l0a_q, l0b_q;
  logic signed [ProdW-1:0] prod1_q, prod2_q;
  logic signed [ValueW-1:0] qval_q;
  logic sat_q;

  // Output register.
  logic               out_valid_q;
  logic [KindW-1:0]   out_kind_q;
  logic [ValueW-1:0]  out_value_q;
  logic [SizeW-1:0]   out_size_q;

  // RAM ports.
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [WordW-1:0]  wdata, rdata;
  logic signed [CoefW-1:0] rd_a, rd_b;

  mleq_ram #(.Width(WordW), .Depth(MAX_LINES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_a = rdata[CoefW-1:0];
  assign rd_b = rdata[WordW-1:CoefW];

  // Comparisons on the freshly read line and on the registered products.
  logic sort_gt, eq_dom, cv_le, step_up;
  logic signed [MulW-1:0] qdiff;
  assign sort_gt = (rd_a > ca_q) || ((rd_a == ca_q) && (rd_b > cb_q));
  assign eq_dom  = (rd_a == ca_q) && (rd_b <= cb_q);
  assign cv_le   = prod1_q <= prod2_q;
  assign qdiff   = MulW'(l1b_q) - MulW'(l0b_q);
  assign step_up = ProdW'(qdiff) <= prod2_q;

  // Shift with saturation to the 32-bit range.
  logic signed [MulW-1:0]  sum_a, sum_b;
  logic signed [CoefW-1:0] sat_a, sat_b;
  logic                    ovf_a, ovf_b;
  assign sum_a = MulW'(rd_a) + MulW'(s_q);
  assign sum_b = MulW'(rd_b) + MulW'(c_q);
  assign ovf_a = sum_a[MulW-1] != sum_a[MulW-2];
  assign ovf_b = sum_b[MulW-1] != sum_b[MulW-2];
  assign sat_a = ovf_a ? {sum_a[MulW-1], {(CoefW-1){~sum_a[MulW-1]}}} : sum_a[CoefW-1:0];
  assign sat_b = ovf_b ? {sum_b[MulW-1], {(CoefW-1){~sum_b[MulW-1]}}} : sum_b[CoefW-1:0];

  // Shared multiplier operand selection.
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  always_comb begin
    mul_a = MulW'(x_q);
    mul_b = MulW'(l1a_q);
    case (cmd_i.op)
      DP_MUL1: begin
        mul_a = MulW'(l1b_q) - MulW'(cb_q);
        mul_b = MulW'(l1a_q) - MulW'(l0a_q);
      end
      DP_MUL2: begin
        mul_a = MulW'(l0b_q) - MulW'(l1b_q);
        mul_b = MulW'(ca_q) - MulW'(l1a_q);
      end
      DP_Q_MUL: begin
        mul_a = MulW'(x_q);
        mul_b = MulW'(l0a_q) - MulW'(l1a_q);
      end
      default: ;
    endcase
  end
  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  assign mid_sum = (CW + 1)'(lo_q) + (CW + 1)'(hi_q);
  assign mid_c   = mid_sum[CW:1];

  // RAM address and write selection.
  always_comb begin
    we    = 1'b0;
    waddr = j_q[AW-1:0];
    wdata = {cb_q, ca_q};
    raddr = i_q[AW-1:0];
    case (cmd_i.op)
      DP_ADD: begin
        we    = 1'b1;
        waddr = cnt_q[AW-1:0];
        wdata = {c_q, s_q};
      end
      DP_SORT_INS: we = 1'b1;
      DP_SORT_CMP: begin
        we = 1'b1;
        if (sort_gt) begin
          wdata = rdata;
        end
      end
      DP_PUSH: begin
        we    = 1'b1;
        waddr = top_q[AW-1:0];
      end
      DP_SH_WR: begin
        we    = 1'b1;
        waddr = i_q[AW-1:0];
        wdata = {sat_b, sat_a};
      end
      DP_RD_JM1:     raddr = AW'(j_q - 1'b1);
      DP_RD_TOP1:    raddr = AW'(top_q - 1'b1);
      DP_L1_RD_TOP2: raddr = AW'(top_q - CW'(2));
      DP_Q_MID:      raddr = mid_c[AW-1:0];
      DP_Q_RD2:      raddr = AW'(mid_q + 1'b1);
      DP_Q_RDLO:     raddr = lo_q[AW-1:0];
      default: ;
    endcase
  end

  // Working registers; every use is preceded by a load.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        op_q  <= in_op_i;
        s_q   <= in_data_i[CoefW-1:0];
        c_q   <= in_data_i[2*CoefW-1:CoefW];
        x_q   <= in_data_i[3*CoefW-1:2*CoefW];
        sat_q <= 1'b0;
      end
      DP_SET_I1: i_q <= CW'(1);
      DP_H_INIT: begin
        i_q   <= '0;
        top_q <= '0;
      end
      DP_CUR_LD: begin
        ca_q <= rd_a;
        cb_q <= rd_b;
        j_q  <= i_q;
      end
      DP_SORT_INS: i_q <= i_q + 1'b1;
      DP_SORT_CMP: begin
        if (sort_gt) begin
          j_q <= j_q - 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      DP_EQ_CHK: begin
        if (eq_dom) begin
          top_q <= top_q - 1'b1;
        end
      end
      DP_L1_RD_TOP2: begin
        l1a_q <= rd_a;
        l1b_q <= rd_b;
      end
      DP_L0_LD, DP_Q_L0: begin
        l0a_q <= rd_a;
        l0b_q <= rd_b;
      end
      DP_MUL1, DP_Q_F2: prod1_q <= prod;
      DP_MUL2, DP_Q_MUL: prod2_q <= prod;
      DP_CV_CMP: begin
        if (cv_le) begin
          top_q <= top_q - 1'b1;
        end
      end
      DP_PUSH: begin
        top_q <= top_q + 1'b1;
        i_q   <= i_q + 1'b1;
      end
      DP_Q_INIT: begin
        lo_q   <= '0;
        hi_q   <= hcnt_q - 1'b1;
        qval_q <= '0;
      end
      DP_Q_MID: mid_q <= mid_c;
      DP_Q_RD2, DP_Q_F1: begin
        l1a_q <= rd_a;
        l1b_q <= rd_b;
      end
      DP_Q_STEP: begin
        if (step_up) begin
          lo_q <= mid_q + 1'b1;
        end else begin
          hi_q <= mid_q;
        end
      end
      DP_Q_F3: qval_q <= prod1_q[ValueW-1:0] + ValueW'(l1b_q);
      DP_SH_I0: i_q <= '0;
      DP_SH_WR: begin
        i_q   <= i_q + 1'b1;
        sat_q <= sat_q | ovf_a | ovf_b;
      end
      default: ;
    endcase
  end

  // Line and hull counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      hcnt_q <= '0;
    end else begin
      case (cmd_i.op)
        DP_ADD: cnt_q <= cnt_q + 1'b1;
        DP_CLEAR: begin
          cnt_q  <= '0;
          hcnt_q <= '0;
        end
        DP_BUILD_END: begin
          cnt_q  <= top_q;
          hcnt_q <= top_q;
        end
        default: ;
      endcase
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_kind_q  <= cmd_i.kind;
      out_value_q <= (cmd_i.kind == KIND_QUERY) ? qval_q : '0;
      out_size_q  <= ((cmd_i.kind == KIND_QUERY) || (cmd_i.kind == KIND_BUILD)) ?
                     SizeW'(hcnt_q) : SizeW'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = {1'b0, out_size_q, out_value_q};

  // Status back to the controller.
  always_comb begin
    stat_o.op         = op_q;
    stat_o.full       = cnt_q >= CW'(MAX_LINES);
    stat_o.hull_empty = hcnt_q == '0;
    stat_o.i_lt_cnt   = i_q < cnt_q;
    stat_o.j_zero     = j_q == '0;
    stat_o.top_gt0    = top_q != '0;
    stat_o.top_gt1    = top_q > CW'(1);
    stat_o.sort_gt    = sort_gt;
    stat_o.eq_dom     = eq_dom;
    stat_o.cv_le      = cv_le;
    stat_o.lo_lt_hi   = lo_q < hi_q;
    stat_o.sat        = sat_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

// File: sv/max_line_envelope_query.sv
// Upper envelope of up to MAX_LINES lines. One request at a time.
// Add on a full store returns a full result. Shift visits every stored line,
// with one more step when it saturates. Query is a binary search over the
// hull, cut short on an empty hull. Build: insertion sort by slope, then a
// hull pass that drops lines of equal slope and lines the others cover.
// Asynchronous active-low reset empties the store; no RAM clearing pass.
module max_line_envelope_query #(
  parameter int unsigned MAX_LINES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // slope [31:0], intercept [63:32], query_x [95:64]
  input  logic [mleq_pkg::InDataW-1:0]  s_axis_tdata,
  // op [2:0]
  input  logic [mleq_pkg::OpW-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // value [63:0], hull_size [70:64], zero [71]
  output logic [mleq_pkg::OutDataW-1:0] m_axis_tdata,
  // kind [1:0]
  output logic [mleq_pkg::KindW-1:0]    m_axis_tuser
);
  import mleq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  mleq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mleq_dp #(.MAX_LINES(MAX_LINES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: sv/mleq_checker.sv
// Port checker for the line envelope query block, bound to the top level.
// Depends on mleq_pkg.
module mleq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mleq_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [mleq_pkg::KindW-1:0]    m_axis_tuser
);
  import mleq_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // One request at a time: the block is busy right after accepting one.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // Only query results carry a value.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_QUERY) |-> m_axis_tdata[ValueW-1:0] == '0)
    else $error("nonzero value on a non-query result");

endmodule

bind max_line_envelope_query mleq_checker u_mleq_checker (.*);
